// File: rtl/core/rsqrt_estimate_normal_mantissa_macros.svh
// assertion macros for the rsqrt estimate rtl
// expects signals clk and rst_n in the scope of each use
`ifndef RSQRT_ESTIMATE_NORMAL_MANTISSA_MACROS_SVH
`define RSQRT_ESTIMATE_NORMAL_MANTISSA_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rse_pkg.sv
// types, constants and coefficient rom for the rsqrt estimate block
// no dependencies
`timescale 1ns / 1ps

package rse_pkg;

    // raw interpolated estimate, only bits 25:0 ever reach the result
    typedef logic [25:0] est_t;

    // one rom word: slope in the high half, base in the low half
    typedef struct packed {
        logic [15:0] slope;
        logic [15:0] base;
    } coef_t;

    localparam logic [8:0]  EXP_BIAS  = 9'd127;
    localparam logic [24:0] ROUND_INC = 25'd4;

    // fixed 32-entry coefficient rom, index is {exponent parity, mantissa[22:19]}
    function automatic coef_t rse_coef(input logic [4:0] idx);
        logic [31:0] word;
        begin
            case (idx)
                5'd0:    word = 32'h0568B4FD;
                5'd1:    word = 32'h04F3AF97;
                5'd2:    word = 32'h048DAAA5;
                5'd3:    word = 32'h0435A618;
                5'd4:    word = 32'h03E7A1E4;
                5'd5:    word = 32'h03A29DFE;
                5'd6:    word = 32'h03659A5C;
                5'd7:    word = 32'h032E96F8;
                5'd8:    word = 32'h02FC93CA;
                5'd9:    word = 32'h02D090CE;
                5'd10:   word = 32'h02A88DFE;
                5'd11:   word = 32'h02838B57;
                5'd12:   word = 32'h026188D4;
                5'd13:   word = 32'h02438673;
                5'd14:   word = 32'h02268431;
                5'd15:   word = 32'h020B820B;
                5'd16:   word = 32'h03D27FFA;
                5'd17:   word = 32'h03807C29;
                5'd18:   word = 32'h033878AA;
                5'd19:   word = 32'h02F97572;
                5'd20:   word = 32'h02C27279;
                5'd21:   word = 32'h02926FB7;
                5'd22:   word = 32'h02666D26;
                5'd23:   word = 32'h023F6AC0;
                5'd24:   word = 32'h021D6881;
                5'd25:   word = 32'h01FD6665;
                5'd26:   word = 32'h01E16468;
                5'd27:   word = 32'h01C76287;
                5'd28:   word = 32'h01AF60C1;
                5'd29:   word = 32'h01995F12;
                5'd30:   word = 32'h01855D79;
                5'd31:   word = 32'h01735BF4;
                default: word = 32'h01735BF4;
            endcase
            return coef_t'(word);
        end
    endfunction

endpackage

// File: rtl/core/rse_interp.sv
// coefficient lookup and linear interpolation of the mantissa estimate
// depends on rse_pkg
`timescale 1ns / 1ps

module rse_interp
    import rse_pkg::*;
(
    input  logic [31:0] float_bits,
    output est_t        est
);

    coef_t       coef;
    logic [4:0]  rom_idx;
    logic [9:0]  frac;
    logic [25:0] base_sh;
    logic [25:0] prod;

    // rom index from exponent parity and top mantissa bits
    assign rom_idx = {float_bits[23], float_bits[22:19]};
    assign coef    = rse_coef(rom_idx);
    assign frac    = float_bits[18:9];

    // base scaled by 2^10 minus fraction times slope, wrapping in 26 bits
    assign base_sh = {coef.base, 10'b0};
    assign prod    = {16'b0, frac} * {10'b0, coef.slope};
    assign est     = base_sh - prod;

endmodule

// File: rtl/core/rse_norm.sv
// normalize, round and pack the estimate into a single-precision word
// depends on rse_pkg
`timescale 1ns / 1ps

module rse_norm
    import rse_pkg::*;
(
    input  est_t        est,
    output logic [31:0] estimate_bits
);

    logic [4:0]  lz;
    logic [4:0]  sh;
    logic [24:0] norm;
    logic [24:0] rnd;
    logic [8:0]  expo;

    // leading zeros of bits 24:0, 25 when all clear
    always_comb
    begin
        lz = 5'd25;
        for (int i = 0; i < 25; i++)
        begin
            if (est[i])
            begin
                lz = 5'(24 - i);
            end
        end
    end

    // shift so the leading one lands above bit 24, exponent drops to match
    always_comb
    begin
        sh = lz + 5'd1;
        if (est[25])
        begin
            norm = est[24:0];
            expo = EXP_BIAS;
        end
        else
        begin
            norm = est[24:0] << sh;
            expo = EXP_BIAS - {4'b0, sh};
        end
    end

    // round up on bit 1 with bit 0 or bit 2 set, carry out of bit 24 is dropped
    always_comb
    begin
        if (norm[1] && (norm[0] || norm[2]))
        begin
            rnd = norm + ROUND_INC;
        end
        else
        begin
            rnd = norm;
        end
    end

    assign estimate_bits = {expo, rnd[24:2]};

endmodule

// File: rtl/core/rsqrt_estimate_normal_mantissa.sv
// An input transfer is registered in the operand register, its estimate in
// the result register. Throughput: one transfer per cycle while out_stall is
// low; the datapath is one pass of rom lookup, 10x16 multiply, subtract,
// leading-zero normalize and round between the two registers.
// Reset: asynchronous, clears the two stage valid flags; no other state is reset.
`timescale 1ns / 1ps
`include "rsqrt_estimate_normal_mantissa_macros.svh"

module rsqrt_estimate_normal_mantissa
    import rse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] float_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] estimate_bits
);

    logic        op_valid_reg;
    logic        op_valid_next;
    logic [31:0] operand_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [31:0] result_reg;
    est_t        est;
    logic [31:0] result_comb;
    logic        res_load;
    logic        op_load;

    // stage enables: result stage moves when empty or drained
    assign res_load = !res_valid_reg || !out_stall;
    assign op_load  = !op_valid_reg || res_load;
    assign in_stall = !op_load;

    assign op_valid_next  = op_load ? in_valid : op_valid_reg;
    assign res_valid_next = res_load ? op_valid_reg : res_valid_reg;

    // datapath between operand and result registers
    rse_interp u_interp (
        .float_bits (operand_reg),
        .est        (est)
    );

    rse_norm u_norm (
        .est           (est),
        .estimate_bits (result_comb)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (op_load && in_valid)
        begin
            operand_reg <= float_bits;
        end
        if (res_load && op_valid_reg)
        begin
            result_reg <= result_comb;
        end
    end

    assign out_valid     = res_valid_reg;
    assign estimate_bits = result_reg;

    // checks
    `RSE_ASSERT_NOW(a_stall_only_full, in_stall, op_valid_reg && res_valid_reg && out_stall, "input stalled while pipeline has room")
    `RSE_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, op_valid_reg, "accepted transfer did not reach operand stage")
    `RSE_ASSERT_NEXT(a_advance_fills, op_valid_reg && res_load, out_valid, "operand stage advanced but no result valid")
    `RSE_ASSERT_NOW(a_exp_range, out_valid, (estimate_bits[31:23] <= EXP_BIAS) && (estimate_bits[31:23] >= 9'd101), "result exponent out of range")

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for rsqrt_estimate_normal_mantissa
// depends on the rtl of the block; the predictor keeps its own coefficient table
`timescale 1ns / 1ps

module tb_top;

    // checks each estimate against the oldest predicted one
    class rsqrt_scoreboard;
        logic [31:0] coef_rom [32];
        logic [31:0] expected_q [$];
        int unsigned fails;

        function new();
            coef_rom = '{
                32'h0568B4FD, 32'h04F3AF97, 32'h048DAAA5, 32'h0435A618,
                32'h03E7A1E4, 32'h03A29DFE, 32'h03659A5C, 32'h032E96F8,
                32'h02FC93CA, 32'h02D090CE, 32'h02A88DFE, 32'h02838B57,
                32'h026188D4, 32'h02438673, 32'h02268431, 32'h020B820B,
                32'h03D27FFA, 32'h03807C29, 32'h033878AA, 32'h02F97572,
                32'h02C27279, 32'h02926FB7, 32'h02666D26, 32'h023F6AC0,
                32'h021D6881, 32'h01FD6665, 32'h01E16468, 32'h01C76287,
                32'h01AF60C1, 32'h01995F12, 32'h01855D79, 32'h01735BF4
            };
            fails = 0;
        endfunction

        // base << 10 minus slope times mantissa[18:9], normalize, round
        function logic [31:0] predict_estimate(logic [31:0] x);
            logic [31:0] coef;
            logic [31:0] est;
            logic [31:0] adj;
            logic [31:0] lead;
            coef = coef_rom[{x[23], x[22:19]}];
            est = ((coef << 10) & 32'h03FF_FC00) - (32'(x[18:9]) * 32'(coef[31:16]));
            adj = 32'd0;
            if (!est[25])
            begin
                // leading zeros of bits 24:0 within a 32-bit word
                lead = 32'd32;
                for (int b = 0; b <= 24; b++)
                begin
                    if (est[b])
                        lead = 32'd31 - 32'(b);
                end
                adj = 32'd6 - lead;
                est = est << (lead - 32'd6);
            end
            // round to nearest even on bit 2, carry out of bit 24 is lost
            if (est[1] && (est[0] || est[2]))
                est = est + 32'd4;
            return (32'h3F80_0000 + adj * 32'h0080_0000) | ((est >> 2) & 32'h007F_FFFF);
        endfunction

        function void note_operand(logic [31:0] x);
            expected_q.push_back(predict_estimate(x));
        endfunction

        function void check_estimate(logic [31:0] got);
            logic [31:0] want;
            if (expected_q.size() == 0)
            begin
                $error("estimate_bits: expected none, actual %h", got);
                fails++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $error("estimate_bits: expected %h, actual %h", want, got);
                    fails++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 450;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] float_bits;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] estimate_bits;

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned cycle_count = 0;

    rsqrt_scoreboard sb = new();

    rsqrt_estimate_normal_mantissa dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .float_bits    (float_bits),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .estimate_bits (estimate_bits)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_estimate(estimate_bits);
    end

    // present one operand, with random idle cycles ahead of it, until transfer
    task automatic send_operand(input logic [31:0] x);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        float_bits <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_operand(x);
    endtask

    // random operand, sometimes with the interpolation field at an extreme
    function automatic logic [31:0] random_operand();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(7))
            0: x[18:9] = 10'h3FF;
            1: x[18:9] = 10'h000;
            default: ;
        endcase
        return x;
    endfunction

    logic [31:0] directed_ops [22] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'h0080_0000,
        32'h00FF_FFFF, 32'hFF7F_FFFF, 32'hFF80_0000, 32'h0007_FE00,
        32'h0078_0000, 32'h007F_FE00, 32'h0087_FE00, 32'h00FF_FE00,
        32'h00F8_01FF, 32'h8000_0000, 32'h7F00_0000, 32'h3F80_0000,
        32'h4000_0000, 32'h0055_5555, 32'h002A_AAAA, 32'h00AA_AAAA,
        32'h00D5_5555, 32'h0000_01FF
    };

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        float_bits  <= 32'd0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 76;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 76;
                end
                default:
                begin
                    idle_pct = 32;
                    stall_pct = 32;
                end
            endcase
            if (phase == 0)
            begin
                foreach (directed_ops[i])
                    send_operand(directed_ops[i]);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_operand(random_operand());
        end
        in_valid <= 1'b0;

        // drain outstanding estimates
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.fails == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
